@@ src/tsbl_pkg.sv @@
// shared types and constants of the tag storage block lookup core
package tsbl_pkg;

   localparam int FRAME_BITS   = 36;
   localparam int END_BITS     = FRAME_BITS + 1;
   localparam int DATA_PER_TAG = 32;
   localparam int TAG_SHIFT    = $clog2(DATA_PER_TAG);
   localparam int OFF_BITS     = FRAME_BITS - TAG_SHIFT;
   localparam int BP_BITS      = 13;
   localparam int IDX_BITS     = 5;
   localparam int CNT_BITS     = 6;
   localparam int ORDER_BITS   = 4;
   localparam int SPAN_BITS    = BP_BITS + (2 ** ORDER_BITS) - 1 - TAG_SHIFT;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [IDX_BITS-1:0]   entry_index;
      logic [FRAME_BITS-1:0] entry_mem_start;
      logic [FRAME_BITS-1:0] entry_mem_end;
      logic [FRAME_BITS-1:0] entry_tag_start;
      logic [FRAME_BITS-1:0] entry_tag_end;
      logic [BP_BITS-1:0]    entry_block_pages;
      logic [FRAME_BITS-1:0] lookup_pfn;
      logic [ORDER_BITS-1:0] lookup_order;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [IDX_BITS-1:0]   region_index;
      logic [FRAME_BITS-1:0] first_block;
      logic [END_BITS-1:0]   limit_block;
      logic [BP_BITS-1:0]    block_pages;
      logic                  is_tag_storage;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] mem_start;
      logic [FRAME_BITS-1:0] mem_end;
      logic [FRAME_BITS-1:0] tag_start;
      logic [FRAME_BITS-1:0] tag_end;
      logic [BP_BITS-1:0]    block_pages;
   } entry_type;

   typedef struct packed {
      logic write;
      logic start;
      logic eval;
      logic div_load;
      logic div_step;
      logic sub;
      logic add;
      logic chk;
      logic next;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic none_enabled;
      logic candidate;
      logic div_last;
      logic last;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

@@ src/tsbl_ram.sv @@
// generic single write port ram with registered read
module tsbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/tsbl_datapath.sv @@
// region table, range compares, serial remainder unit and result register
module tsbl_datapath
   import tsbl_pkg::*;
#(
   parameter int MAX_REGIONS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_sts_type        sts,
   input  req_type             req_data,
   input  logic                csr_valid,
   input  logic [CNT_BITS-1:0] csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);
   localparam int RIDX_BITS = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CMP_BITS  = CNT_BITS + 1;
   localparam int DCNT_BITS = $clog2(OFF_BITS);

   logic [CNT_BITS-1:0]   region_count_ff;
   logic [FRAME_BITS-1:0] pfn_ff;
   logic [ORDER_BITS-1:0] order_ff;
   logic [RIDX_BITS-1:0]  idx_ff;
   logic [OFF_BITS-1:0]   off_ff;
   logic [OFF_BITS-1:0]   off_sh_ff;
   logic [BP_BITS-1:0]    rem_ff;
   logic [BP_BITS-1:0]    rem_in;
   logic [DCNT_BITS-1:0]  div_cnt_ff;
   logic [OFF_BITS-1:0]   base_ff;
   logic [END_BITS-1:0]   blk_ff;
   logic                  found_ff;
   logic                  tagst_ff;
   logic [RIDX_BITS-1:0]  ridx_ff;
   logic [FRAME_BITS-1:0] sb_ff;
   logic [END_BITS-1:0]   eb_ff;
   logic [BP_BITS-1:0]    bp_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   entry_type             wr_entry;
   entry_type             rd_entry;
   logic [$bits(entry_type)-1:0] rd_raw;
   logic                  wr_en;
   logic [CMP_BITS-1:0]   enabled;
   logic [FRAME_BITS-1:0] diff;
   logic                  tag_hit;
   logic [BP_BITS:0]      trial;
   logic [BP_BITS:0]      bsz_ext;
   logic [END_BITS:0]     last_pg;
   logic                  fits;
   logic [ORDER_BITS-1:0] shamt;
   logic [SPAN_BITS-1:0]  span;
   logic [END_BITS-1:0]   eb_next;

   // table write, slots past the table are dropped
   assign wr_en = cmd.write && (32'(req_data.entry_index) < MAX_REGIONS);
   assign wr_entry.mem_start   = req_data.entry_mem_start;
   assign wr_entry.mem_end     = req_data.entry_mem_end;
   assign wr_entry.tag_start   = req_data.entry_tag_start;
   assign wr_entry.tag_end     = req_data.entry_tag_end;
   assign wr_entry.block_pages = req_data.entry_block_pages;

   tsbl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (RIDX_BITS'(req_data.entry_index)),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_raw)
   );
   assign rd_entry = entry_type'(rd_raw);

   // enabled count saturates at the table depth
   always_comb begin
      if ({1'b0, region_count_ff} > CMP_BITS'(MAX_REGIONS)) begin
         enabled = CMP_BITS'(MAX_REGIONS);
      end else begin
         enabled = {1'b0, region_count_ff};
      end
   end

   assign diff    = pfn_ff - rd_entry.mem_start;
   assign tag_hit = (rd_entry.tag_start <= pfn_ff) && (pfn_ff <= rd_entry.tag_end);

   // one remainder bit per step
   assign bsz_ext = {1'b0, rd_entry.block_pages};
   assign trial   = {rem_ff, off_sh_ff[OFF_BITS-1]};
   always_comb begin
      if (trial >= bsz_ext) begin
         rem_in = BP_BITS'(trial - bsz_ext);
      end else begin
         rem_in = trial[BP_BITS-1:0];
      end
   end

   assign last_pg = (END_BITS+1)'(blk_ff) + (END_BITS+1)'(rd_entry.block_pages)
                    - (END_BITS+1)'(1);
   assign fits    = last_pg <= (END_BITS+1)'(rd_entry.tag_end);

   // block count is a power of two, so count times size is a shift
   assign shamt   = (order_ff >= ORDER_BITS'(TAG_SHIFT)) ?
                    (order_ff - ORDER_BITS'(TAG_SHIFT)) : '0;
   assign span    = SPAN_BITS'(rd_entry.block_pages) << shamt;
   assign eb_next = blk_ff + END_BITS'(span);

   assign sts.none_enabled = (region_count_ff == '0);
   assign sts.candidate    = !found_ff && (rd_entry.block_pages != '0) &&
                             (rd_entry.mem_start <= pfn_ff) && (pfn_ff <= rd_entry.mem_end);
   assign sts.div_last     = (div_cnt_ff == DCNT_BITS'(OFF_BITS - 1));
   assign sts.last         = (CMP_BITS'(idx_ff) + CMP_BITS'(1)) >= enabled;
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         found_ff        <= 1'b0;
         tagst_ff        <= 1'b0;
         idx_ff          <= '0;
      end else begin
         if (csr_valid) begin
            region_count_ff <= csr_data;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.start) begin
            found_ff <= 1'b0;
            tagst_ff <= 1'b0;
            idx_ff   <= '0;
         end else begin
            if (cmd.eval && tag_hit) begin
               tagst_ff <= 1'b1;
            end
            if (cmd.chk && fits) begin
               found_ff <= 1'b1;
            end
            if (cmd.next) begin
               idx_ff <= idx_ff + RIDX_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pfn_ff   <= req_data.lookup_pfn;
         order_ff <= req_data.lookup_order;
         ridx_ff  <= '0;
         sb_ff    <= '0;
         eb_ff    <= '0;
         bp_ff    <= '0;
      end
      if (cmd.div_load) begin
         off_ff     <= diff[FRAME_BITS-1:TAG_SHIFT];
         off_sh_ff  <= diff[FRAME_BITS-1:TAG_SHIFT];
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= rem_in;
         off_sh_ff  <= {off_sh_ff[OFF_BITS-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + DCNT_BITS'(1);
      end
      if (cmd.sub) begin
         base_ff <= off_ff - OFF_BITS'(rem_ff);
      end
      if (cmd.add) begin
         blk_ff <= END_BITS'(rd_entry.tag_start) + END_BITS'(base_ff);
      end
      if (cmd.chk && fits) begin
         ridx_ff <= idx_ff;
         sb_ff   <= blk_ff[FRAME_BITS-1:0];
         eb_ff   <= eb_next;
         bp_ff   <= rd_entry.block_pages;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.found          <= found_ff;
         rsp_data_ff.region_index   <= IDX_BITS'(ridx_ff);
         rsp_data_ff.first_block    <= sb_ff;
         rsp_data_ff.limit_block    <= eb_ff;
         rsp_data_ff.block_pages    <= bp_ff;
         rsp_data_ff.is_tag_storage <= tagst_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

@@ src/tsbl_ctrl.sv @@
// sequencer for the region scan and the per-region block check
module tsbl_ctrl
   import tsbl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_command,
   output logic         req_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FETCH = 8'b0000_0010,
      ST_EVAL  = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_SUB   = 8'b0001_0000,
      ST_ADD   = 8'b0010_0000,
      ST_CHK   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_LOOKUP) begin
                  cmd.start = 1'b1;
                  state_in  = sts.none_enabled ? ST_DONE : ST_FETCH;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.candidate) begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end else if (sts.last) begin
               state_in = ST_DONE;
            end else begin
               cmd.next = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.chk = 1'b1;
            if (sts.last) begin
               state_in = ST_DONE;
            end else begin
               cmd.next = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ src/tag_storage_block_lookup_core.sv @@
// top level of the tag storage block lookup core
//
// Holds a table of tag-storage regions (data frame range, tag frame range and
// tag block size) and answers lookups on a page frame and allocation order.
// A write beat fills one table slot in its accept cycle and returns nothing;
// slots at or above MAX_REGIONS are dropped. A lookup beat scans the first
// region_count slots (saturated at MAX_REGIONS) from slot 0 upward and always
// returns one beat: the first region whose data range holds the frame and
// whose rounded tag block fits its tag range, plus a flag that says whether
// the frame lies in any enabled tag range. Each enabled region passes through
// a fetch state and an evaluate state; every region with a nonzero block size
// that holds the frame in its data range, up to and including the first
// match, also runs a one-bit-per-cycle remainder of the tag offset by the
// block size (31 steps), then states for the block base, the address add and
// the range check. Slots are read from a table with one write port and a
// registered read port. Lookups are taken one at a time; a finished result
// waits in the output register while the next beat is accepted. Slots that
// were never written must not be enabled. csr_ready is always high;
// region_count must be written only while the core is idle, which the core
// itself does not enforce.
module tag_storage_block_lookup_core
   import tsbl_pkg::*;
#(
   parameter int MAX_REGIONS = 32
) (
   input  logic                clock,
   input  logic                reset,
   // lookup and table write beats
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   // lookup results
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   // region_count register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_BITS-1:0] csr_data
);
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // register writes never stall
   assign csr_ready = 1'b1;

   tsbl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // table, compares, remainder unit and output register
   tsbl_datapath #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

@@ sim/tag_storage_block_lookup_core_tb.sv @@
// testbench of the tag storage block lookup core: directed table, then random traffic vs a predictor
`timescale 1ns / 100ps

module tag_storage_block_lookup_core_tb
   import tsbl_pkg::*;
();

   localparam int MAX_REGIONS  = 32;
   localparam int PHASES       = 16;
   localparam int PHASE_ITEMS  = 88;
   localparam int SETTLE_TICKS = 8;     // a table write lands in its accept cycle
   localparam int TAIL_TICKS   = 1300;  // covers a worst-case lookup over 32 candidate regions
   localparam int HOLD_TICKS   = 3000;
   // worst run: ~1500 beats, each a full 32-candidate scan plus gaps and stalls,
   // taken about four times over
   localparam int RUN_LIMIT    = 8_000_000;

   typedef enum bit {ROW_COUNT, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CNT_BITS-1:0]   count;
      req_type               beat;
      bit                    typed;
      rsp_type               answer;
   } script_row_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_BITS-1:0] csr_data  = '0;

   // predictor state: region table and region_count as the core should hold them
   entry_type           region_table [MAX_REGIONS];
   logic [CNT_BITS-1:0] region_limit = '0;
   rsp_type             pending_results [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_ticket   = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int mismatch_count = 0;

   tag_storage_block_lookup_core #(
      .MAX_REGIONS(MAX_REGIONS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   function automatic int active_regions();
      return (region_limit > MAX_REGIONS) ? MAX_REGIONS : int'(region_limit);
   endfunction

   // first enabled region whose rounded tag block fits, plus the tag range flag
   function automatic rsp_type lookup_region_table(req_type beat);
      rsp_type         res;
      longint unsigned pfn, off, blk, bsz, nblk;
      res  = '0;
      pfn  = 64'(beat.lookup_pfn);
      nblk = (64'd1 << beat.lookup_order) / DATA_PER_TAG;
      if (nblk == 0) nblk = 1;
      for (int i = 0; i < active_regions(); i++) begin
         bsz = 64'(region_table[i].block_pages);
         if (region_table[i].tag_start <= beat.lookup_pfn &&
             beat.lookup_pfn <= region_table[i].tag_end)
            res.is_tag_storage = 1'b1;
         // zero-size regions never match, but still count for the tag flag
         if (!res.found && bsz != 0 &&
             region_table[i].mem_start <= beat.lookup_pfn &&
             beat.lookup_pfn <= region_table[i].mem_end) begin
            off = (pfn - 64'(region_table[i].mem_start)) / DATA_PER_TAG;
            blk = 64'(region_table[i].tag_start) + (off - off % bsz);
            if (blk + bsz - 1 <= 64'(region_table[i].tag_end)) begin
               res.found        = 1'b1;
               res.region_index = IDX_BITS'(i);
               res.first_block  = FRAME_BITS'(blk);
               res.limit_block  = END_BITS'(blk + nblk * bsz);
               res.block_pages  = BP_BITS'(bsz);
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic longint unsigned rand_upto(longint unsigned limit);
      return {$urandom, $urandom} % (limit + 1);
   endfunction

   function automatic logic [FRAME_BITS-1:0] rand_frame();
      return FRAME_BITS'({$urandom, $urandom});
   endfunction

   // every field random, so each bit of each field gets toggled
   function automatic req_type random_beat();
      req_type beat;
      beat.command           = 1'($urandom);
      beat.entry_index       = IDX_BITS'($urandom);
      beat.entry_mem_start   = rand_frame();
      beat.entry_mem_end     = rand_frame();
      beat.entry_tag_start   = rand_frame();
      beat.entry_tag_end     = rand_frame();
      beat.entry_block_pages = BP_BITS'($urandom);
      beat.lookup_pfn        = rand_frame();
      beat.lookup_order      = ORDER_BITS'($urandom);
      return beat;
   endfunction

   // mostly consistent regions: tag range sized to the data range, rounded to blocks
   function automatic req_type make_region(logic [IDX_BITS-1:0] slot);
      req_type         beat;
      longint unsigned base_lim, span, tag_pages, bsz;
      beat             = random_beat();
      beat.command     = CMD_WRITE;
      beat.entry_index = slot;
      if ($urandom_range(99) < 15) return beat;
      // a narrow base window makes regions overlap, so scan order matters
      base_lim = ($urandom_range(1) == 0) ? 64'h3_FFFF : 64'hF_FFF0_0000;
      case ($urandom_range(3))
         0:       span = $urandom_range(1, 64);
         1:       span = $urandom_range(1, 4096);
         default: span = $urandom_range(1, 1 << 18);
      endcase
      case ($urandom_range(9))
         0:       bsz = 0;
         1:       bsz = $urandom_range(4097, 8191);
         2, 3:    bsz = $urandom_range(1, 4096);
         default: bsz = 64'd1 << $urandom_range(6);
      endcase
      beat.entry_mem_start   = FRAME_BITS'(rand_upto(base_lim));
      beat.entry_mem_end     = FRAME_BITS'(64'(beat.entry_mem_start) + span - 1);
      tag_pages = (span + DATA_PER_TAG - 1) / DATA_PER_TAG;
      if (bsz != 0) tag_pages = (tag_pages + bsz - 1) / bsz * bsz;
      // trimmed tag range: the last block no longer fits
      if ($urandom_range(4) == 0 && tag_pages > 1) tag_pages = tag_pages - 1;
      beat.entry_tag_start   = FRAME_BITS'(rand_upto(base_lim));
      beat.entry_tag_end     = FRAME_BITS'(64'(beat.entry_tag_start) + tag_pages - 1);
      beat.entry_block_pages = BP_BITS'(bsz);
      return beat;
   endfunction

   // frames aimed at an enabled region's data range, its tag range or its edges
   function automatic req_type make_lookup();
      req_type     beat;
      int unsigned pick;
      int          slot;
      entry_type   ent;
      beat         = random_beat();
      beat.command = CMD_LOOKUP;
      if ($urandom_range(3) != 0) beat.lookup_order = ORDER_BITS'($urandom_range(10));
      slot = (active_regions() > 0) ? $urandom_range(active_regions() - 1)
                                    : $urandom_range(MAX_REGIONS - 1);
      ent  = region_table[slot];
      pick = $urandom_range(99);
      if (pick < 55) begin
         if (ent.mem_end >= ent.mem_start)
            beat.lookup_pfn = FRAME_BITS'(64'(ent.mem_start) +
                                          rand_upto(64'(ent.mem_end - ent.mem_start)));
      end else if (pick < 70) begin
         if (ent.tag_end >= ent.tag_start)
            beat.lookup_pfn = FRAME_BITS'(64'(ent.tag_start) +
                                          rand_upto(64'(ent.tag_end - ent.tag_start)));
      end else if (pick < 80) begin
         case ($urandom_range(3))
            0:       beat.lookup_pfn = ent.mem_start - 1'b1;
            1:       beat.lookup_pfn = ent.mem_end;
            2:       beat.lookup_pfn = ent.mem_end + 1'b1;
            default: beat.lookup_pfn = ent.tag_end + 1'b1;
         endcase
      end
      return beat;
   endfunction

   function automatic script_row_type set_count(logic [CNT_BITS-1:0] value);
      script_row_type row;
      row       = '{kind: ROW_COUNT, count: value, beat: '0, typed: 1'b0, answer: '0};
      return row;
   endfunction

   function automatic script_row_type fill_slot(int slot,
                                                logic [FRAME_BITS-1:0] ms, me, ts, te,
                                                logic [BP_BITS-1:0] bp);
      script_row_type row;
      row = '{kind: ROW_BEAT, count: '0, beat: '1, typed: 1'b0, answer: '0};
      row.beat.command           = CMD_WRITE;
      row.beat.entry_index       = IDX_BITS'(slot);
      row.beat.entry_mem_start   = ms;
      row.beat.entry_mem_end     = me;
      row.beat.entry_tag_start   = ts;
      row.beat.entry_tag_end     = te;
      row.beat.entry_block_pages = bp;
      return row;
   endfunction

   function automatic script_row_type probe(logic [FRAME_BITS-1:0] pfn, int order,
                                            bit typed = 1'b0, rsp_type answer = '0);
      script_row_type row;
      row = '{kind: ROW_BEAT, count: '0, beat: '0, typed: typed, answer: answer};
      row.beat.command      = CMD_LOOKUP;
      row.beat.lookup_pfn   = pfn;
      row.beat.lookup_order = ORDER_BITS'(order);
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // one beat on the request channel; the predictor follows at the accept edge
   task automatic offer_beat(input req_type beat, input bit typed = 1'b0,
                             input rsp_type answer = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (beat.command == CMD_LOOKUP) begin
         pending_results.push_back(typed ? answer : lookup_region_table(beat));
      end else begin
         region_table[beat.entry_index] = '{beat.entry_mem_start, beat.entry_mem_end,
                                             beat.entry_tag_start, beat.entry_tag_end,
                                             beat.entry_block_pages};
      end
   endtask

   // wait for every lookup to come back, then wait out SETTLE_TICKS for a trailing write
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_region_count(input logic [CNT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      region_limit  = value;
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls, plus a long hold-off when asked for
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_seen != hold_ticket) begin
         hold_seen <= hold_ticket;
         hold_left <= HOLD_TICKS;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result beat with no lookup outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("found", 64'(rsp_data.found), 64'(want.found));
            check_field("region_index", 64'(rsp_data.region_index), 64'(want.region_index));
            check_field("first_block", 64'(rsp_data.first_block), 64'(want.first_block));
            check_field("limit_block", 64'(rsp_data.limit_block), 64'(want.limit_block));
            check_field("block_pages", 64'(rsp_data.block_pages), 64'(want.block_pages));
            check_field("is_tag_storage", 64'(rsp_data.is_tag_storage),
                        64'(want.is_tag_storage));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      script_row_type      script [$];
      logic [CNT_BITS-1:0] next_count;
      req_type             beat;

      script = '{
         // empty table after reset: nothing found, nothing is tag storage
         probe(36'h0, 0, 1'b1, '0),
         probe(36'hF_FFFF_FFFF, 15, 1'b1, '0),
         // plain region, 4-page blocks
         fill_slot(0, 36'h1000, 36'h1FFF, 36'h100, 36'h17F, 13'd4),
         // zero block size over all frames: never matches, tag range still counts
         fill_slot(1, 36'h0, 36'hF_FFFF_FFFF, 36'h1000, 36'h1003, 13'd0),
         // top of the frame space with the largest block size
         fill_slot(2, 36'hF_FFFE_0000, 36'hF_FFFF_FFFF, 36'hF_FFFF_F000, 36'hF_FFFF_FFFF,
                   13'd4096),
         // block size above range, last block one page short
         fill_slot(3, 36'h5_0000_0000, 36'h5_0003_FFFF, 36'h8_0000_0000, 36'h8_0000_1FFE,
                   13'd8191),
         // tag range two pages short: the last block does not fit
         fill_slot(4, 36'h2000, 36'h2FFF, 36'h200, 36'h27D, 13'd4),
         set_count(6'd5),
         probe(36'h1000, 0, 1'b1, '{1'b1, 5'd0, 36'h100, 37'h104, 13'd4, 1'b1}),
         probe(36'h3000, 3, 1'b1, '0),
         probe(36'h1FFF, 5),
         probe(36'h1FE0, 10),
         probe(36'h2F80, 0),
         probe(36'h2F7F, 1),
         probe(36'hF_FFFF_FFFF, 15),
         probe(36'hF_FFFE_0000, 11),
         probe(36'h5_0003_FFFF, 12),
         probe(36'h5_0000_0000, 13),
         probe(36'h150, 14),
         probe(36'h1002, 0),
         // fewer regions enabled: slot 2 drops out
         set_count(6'd2),
         probe(36'hF_FFFF_FFFF, 15)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[s]) begin
         if (script[s].kind == ROW_COUNT) begin
            drain_block();
            write_region_count(script[s].count);
         end else begin
            offer_beat(script[s].beat, script[s].typed, script[s].answer);
         end
      end

      // every slot holds a region before any count can enable it
      for (int slot = 0; slot < MAX_REGIONS; slot++)
         offer_beat(make_region(IDX_BITS'(slot)));

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_block();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 77; end
            default: begin send_idle_pct = 30; rsp_stall_pct <= 30; end
         endcase
         case (phase)
            0: next_count = 6'd32;
            1: next_count = 6'd63;   // saturates to the table size
            2: next_count = 6'd0;
            3: next_count = 6'd1;
            default: begin
               if ($urandom_range(3) == 0) next_count = CNT_BITS'($urandom_range(33, 63));
               else next_count = CNT_BITS'($urandom_range(0, 32));
            end
         endcase
         write_region_count(next_count);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // long result hold-off while beats keep coming: the core fills and stalls
            if (phase == 0 && k == 12) hold_ticket <= hold_ticket + 1;
            if ($urandom_range(99) < 12) beat = make_region(IDX_BITS'($urandom));
            else beat = make_lookup();
            offer_beat(beat);
         end
      end

      drain_block();
      repeat (TAIL_TICKS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
